// ===== src/bblur_pkg.sv =====
// Shared types and constants of the 9x9 box blur core.
package bblur_pkg;

    localparam int SAMPLE_W  = 8;   // one colour sample
    localparam int AVG_W     = 16;  // mean in 8.8 fixed point
    localparam int FRAC_W    = 8;
    localparam int POS_W     = 10;  // row and column of an emitted pixel
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [AVG_W-1:0] MEAN_MAX = 16'hFF00;   // 255.0

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_in;
        logic [SAMPLE_W-1:0] green_in;
        logic [SAMPLE_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [AVG_W-1:0] red_avg;
        logic [AVG_W-1:0] green_avg;
        logic [AVG_W-1:0] blue_avg;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } pix_out_t;

endpackage

// ===== src/bblur_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bblur_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bblur_cell.sv =====
// One cell of the horizontal window chain: holds the column sums of one column.
module bblur_cell #(
    parameter int DATA_W = 36
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift,
    input  logic [DATA_W-1:0] d,
    output logic [DATA_W-1:0] q
);

    logic [DATA_W-1:0] q_reg;

    // cleared so the running total starts equal to the sum of all cells
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (shift) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// ===== src/bblur_mean.sv =====
// Window sum to 8.8 mean: reciprocal multiply, then one correction step and clamp.
module bblur_mean #(
    parameter int TOT_W = 15,
    parameter int AREA  = 81
) (
    input  logic                             aclk,
    input  logic                             en_a,
    input  logic                             en_b,
    input  logic [TOT_W-1:0]                 total,
    output logic [bblur_pkg::AVG_W-1:0]      mean
);

    localparam int N_W = TOT_W + bblur_pkg::FRAC_W;
    localparam int SH  = N_W;
    localparam int P_W = 2 * SH;
    localparam int Q_W = bblur_pkg::AVG_W + 1;
    // floor(2^SH / AREA); estimate is exact or one low since N < 2^SH
    localparam logic [SH-1:0]  RECIP_V = SH'((64'd1 << SH) / AREA);
    localparam logic [N_W-1:0] AREA_V  = N_W'(AREA);

    logic [N_W-1:0]              n_next;
    logic [N_W-1:0]              n_reg;
    logic [P_W-1:0]              prod_next;
    logic [P_W-1:0]              prod_reg;
    logic [Q_W-1:0]              q_est;
    logic [N_W-1:0]              rem;
    logic [Q_W-1:0]              q_fix;
    logic [bblur_pkg::AVG_W-1:0] mean_next;
    logic [bblur_pkg::AVG_W-1:0] mean_reg;

    always_comb begin
        n_next    = N_W'(total) << bblur_pkg::FRAC_W;
        prod_next = P_W'(n_next) * P_W'(RECIP_V);
    end

    always_comb begin
        q_est = prod_reg[SH +: Q_W];
        rem   = n_reg - (N_W'(q_est) * AREA_V);
        q_fix = (rem >= AREA_V) ? q_est + Q_W'(1) : q_est;
        if (q_fix > {1'b0, bblur_pkg::MEAN_MAX}) begin
            mean_next = bblur_pkg::MEAN_MAX;
        end else begin
            mean_next = q_fix[bblur_pkg::AVG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            n_reg    <= n_next;
            prod_reg <= prod_next;
        end
        if (en_b) begin
            mean_reg <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule

// ===== src/box_blur_9x9_rgb_core.sv =====
// Top level of the 9x9 box blur core: line stores, window cell chain, mean pipeline.
//
//   port group      dir   word / meaning
//   s_*             in    pix_in_t: one RGB pixel, raster order
//   m_*             out   pix_out_t: 8.8 means, position, frame_last
//   cfg_*           in    register write: frame_width (0), frame_height (1)
//
// One word per cycle sustained unless m_ready is low or the clearing pass is running.
// Line stores are one RAM per kept row, all read at the pixel's column when it is taken.
// After reset a clearing pass over every address zeroes the line stores; s_ready is low.
// Pipeline stages hold under m_ready low and bubbles close up, so up to five
// words are taken while the output waits.
module box_blur_9x9_rgb_core #(
    parameter int KERNEL_SIZE = 9,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bblur_pkg::pix_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bblur_pkg::pix_out_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bblur_pkg::CFG_W-1:0]       cfg_data
);

    localparam int PAD   = KERNEL_SIZE / 2;
    localparam int SW    = $clog2(KERNEL_SIZE);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CFG_W = bblur_pkg::CFG_W;
    localparam int WDW   = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HDW   = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
    localparam int SMAX  = (1 << bblur_pkg::SAMPLE_W) - 1;
    localparam int CS_W  = $clog2(KERNEL_SIZE * SMAX + 1);
    localparam int TOT_W = $clog2(KERNEL_SIZE * KERNEL_SIZE * SMAX + 1);
    localparam int AREA  = KERNEL_SIZE * KERNEL_SIZE;
    localparam int POS_W = bblur_pkg::POS_W;
    localparam int RXW   = RW + POS_W;
    localparam int CXW   = WDW + POS_W;

    typedef struct packed {
        logic [POS_W-1:0] orow;
        logic [POS_W-1:0] ocol;
        logic             last;
        logic             interior;
    } side_t;

    // configuration and position state
    logic [CFG_W-1:0] w_cfg_reg;
    logic [CFG_W-1:0] h_cfg_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic             clr_reg;
    logic [CW-1:0]    clr_cnt_reg;

    logic [WDW-1:0] w_cfg_x, w_eff, col_x, c_x, ocol_raw;
    logic [HDW-1:0] h_cfg_x, h_eff, row_x, r_x;
    logic [CW-1:0]  c_cur;
    logic [RW-1:0]  r_cur, orow_raw;
    logic [SW-1:0]  slot_cur;
    logic           restart, end_col, end_row, emit;
    logic [RXW-1:0] orow_w;
    logic [CXW-1:0] ocol_w;
    side_t          side_cur;

    // handshake across the stages
    logic en1, en2, en3, en4, en5, acc;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    bblur_pkg::pix_in_t pix1_reg;
    logic [SW-1:0]      slot1_reg;
    side_t              side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;

    bblur_pkg::pix_in_t ram_q [KERNEL_SIZE];
    logic [KERNEL_SIZE-1:0] ram_we;
    logic [CW-1:0]          ram_waddr;
    bblur_pkg::pix_in_t     ram_wdata;

    bblur_pkg::pix_in_t    smp;
    logic [2:0][CS_W-1:0]  cs_next, cs2_reg;
    logic [2:0][CS_W-1:0]  cell_q [KERNEL_SIZE];
    logic                  chain_shift;
    logic [2:0][TOT_W-1:0] tot_reg, tot_next, win3_reg, chk_sum;
    logic [2:0][bblur_pkg::AVG_W-1:0] mean5;

    // ---------------- frame size and position ----------------
    always_comb begin
        w_cfg_x = WDW'(w_cfg_reg);
        h_cfg_x = HDW'(h_cfg_reg);
        if (w_cfg_x < WDW'(KERNEL_SIZE)) begin
            w_eff = WDW'(KERNEL_SIZE);
        end else if (w_cfg_x > WDW'(MAX_WIDTH)) begin
            w_eff = WDW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg_x;
        end
        if (h_cfg_x < HDW'(KERNEL_SIZE)) begin
            h_eff = HDW'(KERNEL_SIZE);
        end else if (h_cfg_x > HDW'(MAX_HEIGHT)) begin
            h_eff = HDW'(MAX_HEIGHT);
        end else begin
            h_eff = h_cfg_x;
        end
    end

    always_comb begin
        col_x    = WDW'(col_reg);
        row_x    = HDW'(row_reg);
        // a size change can leave the counters outside the frame
        restart  = (col_x >= w_eff) || (row_x >= h_eff);
        c_cur    = restart ? '0 : col_reg;
        r_cur    = restart ? '0 : row_reg;
        slot_cur = restart ? '0 : slot_reg;
        c_x      = WDW'(c_cur);
        r_x      = HDW'(r_cur);
        end_col  = (c_x + WDW'(1)) >= w_eff;
        end_row  = (r_x + HDW'(1)) >= h_eff;

        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (acc) begin
            if (end_col) begin
                col_next = '0;
                if (end_row) begin
                    row_next  = '0;
                    slot_next = '0;
                end else begin
                    row_next  = r_cur + RW'(1);
                    slot_next = (slot_cur == SW'(KERNEL_SIZE - 1)) ? '0 : slot_cur + SW'(1);
                end
            end else begin
                col_next  = c_cur + CW'(1);
                row_next  = r_cur;
                slot_next = slot_cur;
            end
        end

        // output lags by PAD rows and PAD pixels, wrapping into the row above
        if (c_x >= WDW'(PAD)) begin
            orow_raw = r_cur - RW'(PAD);
            ocol_raw = c_x - WDW'(PAD);
            emit     = r_x >= HDW'(PAD);
        end else begin
            orow_raw = r_cur - RW'(PAD + 1);
            ocol_raw = c_x + w_eff - WDW'(PAD);
            emit     = r_x >= HDW'(PAD + 1);
        end
        orow_w            = RXW'(orow_raw);
        ocol_w            = CXW'(ocol_raw);
        side_cur.orow     = orow_w[POS_W-1:0];
        side_cur.ocol     = ocol_w[POS_W-1:0];
        side_cur.last     = (r_x == h_eff - HDW'(1)) && (c_x == w_eff - WDW'(1));
        side_cur.interior = (c_x >= WDW'(2 * PAD)) && (r_x >= HDW'(2 * PAD));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_cfg_reg   <= bblur_pkg::WIDTH_RST;
            h_cfg_reg   <= bblur_pkg::HEIGHT_RST;
            col_reg     <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    bblur_pkg::REG_FRAME_WIDTH: begin
                        w_cfg_reg <= cfg_data;
                    end
                    bblur_pkg::REG_FRAME_HEIGHT: begin
                        h_cfg_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            if (clr_reg) begin
                if (clr_cnt_reg == CW'(MAX_WIDTH - 1)) begin
                    clr_reg <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
        end
    end

    // ---------------- stage enables ----------------
    always_comb begin
        en5     = !v5_reg || m_ready;
        en4     = !v4_reg || en5;
        en3     = !v3_reg || en4;
        en2     = !v2_reg || en3;
        en1     = !v1_reg || en2;
        s_ready = en1 && !clr_reg;
        acc     = s_valid && s_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            // warm-up pixels only fill the line store
            if (en1) v1_reg <= acc && emit;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // ---------------- line stores, one per kept row ----------------
    always_comb begin
        ram_waddr = clr_reg ? clr_cnt_reg : c_cur;
        ram_wdata = clr_reg ? '0 : s_data;
    end

    for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_line
        assign ram_we[k] = clr_reg || (acc && (slot_cur == SW'(k)));

        bblur_ram #(
            .DATA_W ($bits(bblur_pkg::pix_in_t)),
            .DEPTH  (MAX_WIDTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we[k]),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (acc),
            .raddr (c_cur),
            .rdata (ram_q[k])
        );
    end

    // ---------------- stage 1: column sums ----------------
    // the current row's slot is replaced by the incoming pixel itself
    always_comb begin
        cs_next = '0;
        smp     = '0;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            smp        = (slot1_reg == SW'(k)) ? pix1_reg : ram_q[k];
            cs_next[2] = cs_next[2] + CS_W'(smp.red_in);
            cs_next[1] = cs_next[1] + CS_W'(smp.green_in);
            cs_next[0] = cs_next[0] + CS_W'(smp.blue_in);
        end
    end

    // ---------------- window chain and running total ----------------
    assign chain_shift = en3 && v2_reg;

    for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_cell
        if (k == 0) begin : g_head
            bblur_cell #(
                .DATA_W (3 * CS_W)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (chain_shift),
                .d       (cs2_reg),
                .q       (cell_q[k])
            );
        end else begin : g_body
            bblur_cell #(
                .DATA_W (3 * CS_W)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (chain_shift),
                .d       (cell_q[k-1]),
                .q       (cell_q[k])
            );
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            tot_next[ch] = tot_reg[ch] + TOT_W'(cs2_reg[ch])
                         - TOT_W'(cell_q[KERNEL_SIZE-1][ch]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_reg <= '0;
        end else if (chain_shift) begin
            tot_reg <= tot_next;
        end
    end

    // ---------------- payload pipeline ----------------
    always_ff @(posedge aclk) begin
        if (en1) begin
            pix1_reg  <= s_data;
            slot1_reg <= slot_cur;
            side1_reg <= side_cur;
        end
        if (en2) begin
            cs2_reg   <= cs_next;
            side2_reg <= side1_reg;
        end
        if (en3) begin
            win3_reg  <= side2_reg.interior ? tot_next : '0;
            side3_reg <= side2_reg;
        end
        if (en4) begin
            side4_reg <= side3_reg;
        end
        if (en5) begin
            side5_reg <= side4_reg;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_mean
        bblur_mean #(
            .TOT_W (TOT_W),
            .AREA  (AREA)
        ) u_mean (
            .aclk  (aclk),
            .en_a  (en4),
            .en_b  (en5),
            .total (win3_reg[ch]),
            .mean  (mean5[ch])
        );
    end

    always_comb begin
        m_valid            = v5_reg;
        m_data.red_avg     = mean5[2];
        m_data.green_avg   = mean5[1];
        m_data.blue_avg    = mean5[0];
        m_data.out_row     = side5_reg.orow;
        m_data.out_col     = side5_reg.ocol;
        m_data.frame_last  = side5_reg.last;
    end

    // ---------------- checks ----------------
    always_comb begin
        chk_sum = '0;
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                chk_sum[ch] = chk_sum[ch] + TOT_W'(cell_q[k][ch]);
            end
        end
    end

    a_total_matches_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> tot_reg == chk_sum)
        else $error("running total differs from sum of window cells");

    a_empty_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg |-> !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg))
        else $error("word in pipeline during line store clearing");

    a_border_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !side5_reg.interior |->
            m_data.red_avg == '0 && m_data.green_avg == '0 && m_data.blue_avg == '0)
        else $error("border pixel with non-zero mean");

    a_last_is_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_last |-> side5_reg.interior)
        else $error("frame_last on a border pixel");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the 9x9 box blur core: random and patterned pixel streams against a software blur.
module tb_top;

    localparam int KSIZE = 9;
    localparam int MAXW  = 1024;
    localparam int MAXH  = 1024;
    localparam int PAD   = KSIZE / 2;
    localparam int SAMPLE_W  = bblur_pkg::SAMPLE_W;
    localparam int AVG_W     = bblur_pkg::AVG_W;
    localparam int POS_W     = bblur_pkg::POS_W;
    localparam int CFG_W     = bblur_pkg::CFG_W;
    localparam int CFG_IDX_W = bblur_pkg::CFG_IDX_W;
    localparam int CFG_TOP   = (1 << CFG_W) - 1;
    localparam int SETTLE    = 8;        // margin for the pipeline to drain
    localparam int CYCLE_CAP = 1500000;

    typedef enum {FILL_RANDOM, FILL_FULL, FILL_PATTERN} fill_e;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    bblur_pkg::pix_in_t   s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    bblur_pkg::pix_out_t  m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = bblur_pkg::REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;

    box_blur_9x9_rgb_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // software copy of the blur state
    logic [3*SAMPLE_W-1:0] rows_kept [KSIZE][MAXW];
    int unsigned           cur_row = 0;
    int unsigned           cur_col = 0;
    logic [CFG_W-1:0]      fw_reg  = bblur_pkg::WIDTH_RST;
    logic [CFG_W-1:0]      fh_reg  = bblur_pkg::HEIGHT_RST;

    bblur_pkg::pix_in_t  pix_pending [$];
    bblur_pkg::pix_out_t mean_expect [$];
    bblur_pkg::pix_out_t mean_due;

    int n_queued = 0;
    int n_taken  = 0;
    int n_seen   = 0;
    int n_fail   = 0;
    int n_writes = 0;
    int n_phases = 0;
    int gap_pct  = 0;
    int stall_pct = 0;
    int gap_left  = 0;
    int hold_left = 0;
    int cycle_count = 0;
    bit calm = 1'b0;

    function automatic logic [AVG_W-1:0] mean88(input int unsigned total);
        int unsigned m;
        m = total * 256 / (KSIZE * KSIZE);
        return (m > bblur_pkg::MEAN_MAX) ? bblur_pkg::MEAN_MAX : AVG_W'(m);
    endfunction

    // store one pixel and work out the blurred word it releases, if any
    task automatic take_pixel(input bblur_pkg::pix_in_t px);
        int unsigned w, h, r, c, dy, dx, tot_r, tot_g, tot_b;
        int orow, ocol;
        logic [3*SAMPLE_W-1:0] kept;
        bblur_pkg::pix_out_t res;
        w = (fw_reg < KSIZE) ? KSIZE : ((fw_reg > MAXW) ? MAXW : fw_reg);
        h = (fh_reg < KSIZE) ? KSIZE : ((fh_reg > MAXH) ? MAXH : fh_reg);
        if (cur_col >= w || cur_row >= h) begin
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        rows_kept[r % KSIZE][c] = px;
        res.frame_last = (r == h - 1) && (c == w - 1);
        if (c + 1 >= w) begin
            cur_col = 0;
            cur_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
        orow = int'(r) - PAD;
        ocol = int'(c) - PAD;
        if (ocol < 0) begin
            ocol += int'(w);
            orow -= 1;
        end
        if (orow >= 0) begin
            tot_r = 0;
            tot_g = 0;
            tot_b = 0;
            // interior implies r and c are at least KSIZE-1, so the window fits
            if (orow >= PAD && orow < int'(h) - PAD && ocol >= PAD && ocol < int'(w) - PAD) begin
                for (dy = 0; dy < KSIZE; dy++) begin
                    for (dx = 0; dx < KSIZE; dx++) begin
                        kept = rows_kept[(r + 1 + dy) % KSIZE][c + 1 + dx - KSIZE];
                        tot_r += kept[3*SAMPLE_W-1:2*SAMPLE_W];
                        tot_g += kept[2*SAMPLE_W-1:SAMPLE_W];
                        tot_b += kept[SAMPLE_W-1:0];
                    end
                end
            end
            res.red_avg   = mean88(tot_r);
            res.green_avg = mean88(tot_g);
            res.blue_avg  = mean88(tot_b);
            res.out_row   = POS_W'(orow);
            res.out_col   = POS_W'(ocol);
            mean_expect.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // driver: feeds pending pixels, predicts on every accepted word
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                take_pixel(s_data);
                n_taken++;
            end
            if (!s_valid || s_ready) begin
                if (!calm && gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
                    gap_left = $urandom_range(0, 11);
                    s_valid <= 1'b0;
                end else if (pix_pending.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pix_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: back-pressure and comparison against the oldest expected word
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (mean_expect.size() == 0) begin
                    $error("word with nothing expected: row %0d col %0d",
                           m_data.out_row, m_data.out_col);
                    n_fail++;
                end else begin
                    mean_due = mean_expect.pop_front();
                    check_field("red_avg",    mean_due.red_avg,    m_data.red_avg);
                    check_field("green_avg",  mean_due.green_avg,  m_data.green_avg);
                    check_field("blue_avg",   mean_due.blue_avg,   m_data.blue_avg);
                    check_field("out_row",    mean_due.out_row,    m_data.out_row);
                    check_field("out_col",    mean_due.out_col,    m_data.out_col);
                    check_field("frame_last", mean_due.frame_last, m_data.frame_last);
                    n_seen++;
                end
            end
            if (calm) begin
                m_ready <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                hold_left = $urandom_range(0, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] edge_sample(input int k);
        case (k % 4)
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'hAA;
            default: return 8'h55;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_size(input int top);
        case ($urandom_range(0, 9))
            0: return CFG_W'($urandom_range(0, KSIZE - 1));
            1: return CFG_W'($urandom_range(MAXW + 1, CFG_TOP));
            default: return CFG_W'($urandom_range(KSIZE, top));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 25;
            default: return 60;
        endcase
    endfunction

    task automatic queue_pixels(input int n, input fill_e fill);
        bblur_pkg::pix_in_t px;
        int k;
        for (k = 0; k < n; k++) begin
            case (fill)
                FILL_FULL: px = '1;
                FILL_PATTERN: begin
                    px.red_in   = edge_sample(k);
                    px.green_in = edge_sample(k + 1);
                    px.blue_in  = edge_sample(k + 2);
                end
                default: begin
                    px.red_in   = pick_sample();
                    px.green_in = pick_sample();
                    px.blue_in  = pick_sample();
                end
            endcase
            pix_pending.push_back(px);
            n_queued++;
        end
        n_phases++;
    endtask

    // wait until every word is in and out, then let the pipeline drain
    task automatic settle();
        while (n_taken != n_queued || mean_expect.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == bblur_pkg::REG_FRAME_WIDTH)
            fw_reg = val;
        else
            fh_reg = val;
        n_writes++;
    endtask

    initial begin
        int i, j, len, n_rand;
        for (i = 0; i < KSIZE; i++)
            for (j = 0; j < MAXW; j++)
                rows_kept[i][j] = '0;
        n_rand = 0;
        gap_pct = 10;
        stall_pct = 10;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset sizes: warm-up only, no words out
        queue_pixels(20, FILL_PATTERN);
        settle();

        // sizes below range clamp to 9x9; old column lies outside, so counters restart
        write_reg(bblur_pkg::REG_FRAME_WIDTH, 11'd0);
        write_reg(bblur_pkg::REG_FRAME_HEIGHT, 11'd8);
        queue_pixels(KSIZE * KSIZE, FILL_FULL);
        queue_pixels(KSIZE * KSIZE, FILL_PATTERN);
        settle();

        // widest row, shortest frame
        gap_pct = 5;
        stall_pct = 5;
        write_reg(bblur_pkg::REG_FRAME_WIDTH, 11'h7FF);
        write_reg(bblur_pkg::REG_FRAME_HEIGHT, 11'd9);
        queue_pixels(MAXW / 8, FILL_RANDOM);
        settle();

        // tallest frame, only partly fed before the next size change
        write_reg(bblur_pkg::REG_FRAME_WIDTH, 11'd9);
        write_reg(bblur_pkg::REG_FRAME_HEIGHT, 11'd1024);
        queue_pixels(KSIZE * 24, FILL_RANDOM);
        settle();

        while (n_rand < 200) begin
            if ($urandom_range(0, 3) != 0) begin
                write_reg(bblur_pkg::REG_FRAME_WIDTH, pick_size(24));
                write_reg(bblur_pkg::REG_FRAME_HEIGHT, pick_size(16));
            end
            gap_pct = pick_pct();
            stall_pct = pick_pct();
            len = $urandom_range(20, 120);
            queue_pixels(len, FILL_RANDOM);
            n_rand += len;
            settle();
        end

        // closing stretch at full rate on both sides
        calm = 1'b1;
        write_reg(bblur_pkg::REG_FRAME_WIDTH, 11'd12);
        write_reg(bblur_pkg::REG_FRAME_HEIGHT, 11'd10);
        queue_pixels(150, FILL_RANDOM);
        settle();

        $display("Streamed %0d pixels in %0d bursts across %0d register writes,",
                 n_taken, n_phases, n_writes);
        $display("including clamped sizes and mid-frame resizes; %0d blurred words compared.",
                 n_seen);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
